>>> rtl/rafc_pkg.sv
// Package for the tag reader ASCII hex frame checker.
// Holds frame byte codes, status codes, stream widths and the hex digit decoder.
// No dependencies.
package rafc_pkg;

    // Framing bytes on the reader's serial line.
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ETX = 8'h03;

    // Default number of id digits in one frame.
    localparam int ID_DIGITS_DEF = 10;

    // Fixed field widths.
    localparam int TAG_W    = 40;
    localparam int CSUM_W   = 8;
    localparam int STATUS_W = 2;

    // Result word: status, tag_id, computed and received checksum, padded to bytes.
    localparam int M_FIELDS_W = STATUS_W + TAG_W + 2 * CSUM_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Frame status reported with each closed frame, lowest priority first.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_BAD_COUNT = 2'd2,
        ST_NON_HEX   = 2'd3
    } frame_status_t;

    // Result of decoding one ASCII byte as a hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_digit_t;

    // Only '0'..'9' and 'A'..'F' are digits; anything else decodes as zero.
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok  = 1'b0;
        d.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.ok  = 1'b1;
            d.nib = c[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.ok  = 1'b1;
            d.nib = 4'(c[3:0] + 4'd9);
        end
        return d;
    endfunction

endpackage

>>> rtl/rfid_ascii_frame_checker.sv
// Top level of the tag reader ASCII hex frame checker.
// Depends on rafc_pkg for byte codes, status codes, widths and the hex decoder.
//
//  Channel | Direction | Ports                       | Contents
//  s_      | in        | s_tvalid s_tready s_tdata   | one received serial byte
//  m_      | out       | m_tvalid m_tready m_tdata   | one result word per byte,
//          |           | m_tuser                     | m_tuser flags a closed frame
//
// Every accepted byte yields exactly one result word: it waits in the input
// register, then passes through the frame logic into the output register once
// that is free. One byte per cycle is sustained while m_tready stays high;
// the frame state update (digit decode, shift and XOR) is the only path that
// carries across bytes. aresetn is synchronous and active low; it empties both
// registers and idles the frame state. A stall on m_tready holds the output
// word and backs up into the input register before s_tready drops.
module rfid_ascii_frame_checker
    import rafc_pkg::*;
#(
    parameter int ID_DIGITS = ID_DIGITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [1:0] status, [41:2] tag_id,
                                            // [49:42] computed_checksum,
                                            // [57:50] received_checksum, rest zero
    output logic                 m_tuser    // [0] frame_done
);

    localparam int CNT_W = $clog2(ID_DIGITS + 4);
    localparam logic [CNT_W-1:0] ID_END    = CNT_W'(ID_DIGITS);
    localparam logic [CNT_W-1:0] DIGIT_END = CNT_W'(ID_DIGITS + 2);
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(ID_DIGITS + 3);

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Frame state.
    logic              receiving_reg, receiving_next;
    logic [CNT_W-1:0]  digit_count_reg, digit_count_next;
    logic [TAG_W-1:0]  id_shift_reg, id_shift_next;
    logic [CSUM_W-1:0] xor_accum_reg, xor_accum_next;
    logic [3:0]        high_nibble_reg, high_nibble_next;
    logic [CSUM_W-1:0] sent_checksum_reg, sent_checksum_next;
    logic              bad_digit_reg, bad_digit_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic                 done_reg, done_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic          process;
    hex_digit_t    digit;
    frame_status_t status;

    // A byte moves through when the output register is free or being emptied.
    assign process  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || process;

    assign in_valid_next = s_tvalid && s_tready ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    assign m_valid_next  = process ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    assign digit = hex_decode(in_byte_reg);

    // Status of a frame being closed, non-hex digit first.
    always_comb begin
        priority if (bad_digit_reg) begin
            status = ST_NON_HEX;
        end else if (digit_count_reg != DIGIT_END) begin
            status = ST_BAD_COUNT;
        end else if (xor_accum_reg != sent_checksum_reg) begin
            status = ST_MISMATCH;
        end else begin
            status = ST_OK;
        end
    end

    // Frame state update and result word for the byte in the input register.
    always_comb begin
        receiving_next     = receiving_reg;
        digit_count_next   = digit_count_reg;
        id_shift_next      = id_shift_reg;
        xor_accum_next     = xor_accum_reg;
        high_nibble_next   = high_nibble_reg;
        sent_checksum_next = sent_checksum_reg;
        bad_digit_next     = bad_digit_reg;
        done_next          = done_reg;
        m_data_next        = m_data_reg;

        if (process) begin
            done_next   = 1'b0;
            m_data_next = '0;
            if (!receiving_reg) begin
                // Idle: only a start byte matters, and it clears the frame.
                if (in_byte_reg == BYTE_STX) begin
                    receiving_next     = 1'b1;
                    digit_count_next   = '0;
                    id_shift_next      = '0;
                    xor_accum_next     = '0;
                    high_nibble_next   = '0;
                    sent_checksum_next = '0;
                    bad_digit_next     = 1'b0;
                end
            end else if (in_byte_reg == BYTE_ETX) begin
                // End byte closes the frame and reports it.
                receiving_next = 1'b0;
                done_next      = 1'b1;
                m_data_next    = M_TDATA_W'({sent_checksum_reg, xor_accum_reg,
                                             id_shift_reg, status});
            end else begin
                // Any other byte is a digit; digits past the checksum only count.
                if (digit_count_reg < DIGIT_END) begin
                    if (!digit.ok) begin
                        bad_digit_next = 1'b1;
                    end
                    if (digit_count_reg < ID_END) begin
                        id_shift_next = {id_shift_reg[TAG_W-5:0], digit.nib};
                        if (!digit_count_reg[0]) begin
                            high_nibble_next = digit.nib;
                        end else begin
                            xor_accum_next = xor_accum_reg ^ {high_nibble_reg, digit.nib};
                        end
                    end else begin
                        sent_checksum_next = {sent_checksum_reg[3:0], digit.nib};
                    end
                end
                if (digit_count_reg < COUNT_CAP) begin
                    digit_count_next = digit_count_reg + 1'b1;
                end
            end
        end
    end

    // Control and frame state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            receiving_reg     <= 1'b0;
            digit_count_reg   <= '0;
            id_shift_reg      <= '0;
            xor_accum_reg     <= '0;
            high_nibble_reg   <= '0;
            sent_checksum_reg <= '0;
            bad_digit_reg     <= 1'b0;
        end else begin
            in_valid_reg      <= in_valid_next;
            m_valid_reg       <= m_valid_next;
            receiving_reg     <= receiving_next;
            digit_count_reg   <= digit_count_next;
            id_shift_reg      <= id_shift_next;
            xor_accum_reg     <= xor_accum_next;
            high_nibble_reg   <= high_nibble_next;
            sent_checksum_reg <= sent_checksum_next;
            bad_digit_reg     <= bad_digit_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        done_reg   <= done_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = done_reg;

endmodule
